>>> src/mte_pkg.sv
// shared types, codes and sizes of the timer expiry table
package mte_pkg;

	// table size and derived widths
	localparam int NUM_TIMERS  = 16;
	localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command codes on the input channel
	localparam logic [2:0] CMD_CONFIG = 3'd0;
	localparam logic [2:0] CMD_START  = 3'd1;
	localparam logic [2:0] CMD_STOP   = 3'd2;
	localparam logic [2:0] CMD_RUN    = 3'd3;
	localparam logic [2:0] CMD_QUERY  = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	// result kinds on the output channel
	localparam logic [1:0] KIND_EXPIRY  = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_QUERY   = 2'd2;

	// remaining times above this count as already passed
	localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		TS_UNUSED    = 2'd0,
		TS_STOPPED   = 2'd1,
		TS_RUNNING   = 2'd2,
		TS_COMPLETED = 2'd3
	} timer_status_t;

	typedef enum logic [2:0] {
		OP_CONFIG,
		OP_START,
		OP_STOP,
		OP_RUN,
		OP_QUERY,
		OP_CLEAR
	} op_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_SUMMARY
	} back_state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  timer_index;
		logic [15:0] callback_param;
		logic [30:0] delay_ms;
		logic [31:0] now_ms;
	} mte_in_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [3:0]  expired_index;
		logic [15:0] expired_param;
		logic [30:0] next_delay_ms;
		logic        is_running;
		logic        last;
	} mte_out_t;

	// classified operation handed from front to back
	typedef struct packed {
		op_kind_t    op;
		logic        idx_ok;
		logic [3:0]  idx;
		logic [15:0] param;
		logic [30:0] delay;
		logic [31:0] now;
	} mte_op_t;

endpackage

>>> src/mte_front.sv
// front end: accepts commands, classifies them and queues them for the back end
module mte_front
	import mte_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  mte_in_t cmd,
	output logic    op_valid,
	input  logic    op_ready,
	output mte_op_t op
);

	mte_op_t             cls_op;
	logic                cls_known;
	logic                push;
	logic                pop;
	mte_op_t             queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	// classify the command; unknown codes are taken and dropped
	always_comb begin
		cls_known     = 1'b1;
		cls_op.op     = OP_CONFIG;
		cls_op.idx_ok = (32'(cmd.timer_index) < NUM_TIMERS);
		cls_op.idx    = cmd.timer_index;
		cls_op.param  = cmd.callback_param;
		cls_op.delay  = cmd.delay_ms;
		cls_op.now    = cmd.now_ms;
		unique case (cmd.command)
			CMD_CONFIG: cls_op.op = OP_CONFIG;
			CMD_START:  cls_op.op = OP_START;
			CMD_STOP:   cls_op.op = OP_STOP;
			CMD_RUN:    cls_op.op = OP_RUN;
			CMD_QUERY:  cls_op.op = OP_QUERY;
			CMD_CLEAR:  cls_op.op = OP_CLEAR;
			default:    cls_known = 1'b0;
		endcase
	end

	// queue handshakes
	assign cmd_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = cmd_valid && cmd_ready && cls_known;
	assign op_valid  = (count_q != '0);
	assign pop       = op_valid && op_ready;
	assign op        = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls_op;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/mte_back.sv
// back end: timer table, run scan sequencer and result register
module mte_back
	import mte_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     op_valid,
	output logic     op_ready,
	input  mte_op_t  op,
	output logic     res_valid,
	input  logic     res_ready,
	output mte_out_t res
);

	back_state_t        state_q;
	back_state_t        state_d;
	timer_status_t      status_q [NUM_TIMERS];
	logic [15:0]        param_q  [NUM_TIMERS];
	logic [31:0]        expiry_q [NUM_TIMERS];
	logic [IDX_W-1:0]   cnt_q;
	logic [31:0]        now_q;
	logic [31:0]        best_q;
	logic               any_q;
	logic               res_valid_q;
	mte_out_t           res_q;

	logic [IDX_W-1:0]   op_addr;
	logic [IDX_W-1:0]   st_addr;
	timer_status_t      rd_status;
	logic [31:0]        diff;
	logic               scan_running;
	logic               expire;
	logic               slot_free;
	logic               take;
	logic               scan_go;
	logic               run_start;
	logic               clear_all;
	logic               st_we;
	timer_status_t      st_wdata;
	logic               store_we;
	logic               emit;
	mte_out_t           emit_data;

	localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(NUM_TIMERS - 1);

	// one status read port, shared by the command and the scan
	assign op_addr      = IDX_W'(op.idx);
	assign st_addr      = (state_q == BK_SCAN) ? cnt_q : op_addr;
	assign rd_status    = status_q[st_addr];
	assign diff         = expiry_q[cnt_q] - now_q;
	assign scan_running = (rd_status == TS_RUNNING);
	assign expire       = scan_running && ((diff == '0) || (diff > HALF_RANGE));
	assign slot_free    = !res_valid_q || res_ready;
	assign take         = op_valid && op_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (take && op.op == OP_RUN) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_go && cnt_q == CNT_LAST) begin
					state_d = BK_SUMMARY;
				end
			end
			BK_SUMMARY: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs: table writes and results
	always_comb begin
		op_ready  = 1'b0;
		scan_go   = 1'b0;
		run_start = 1'b0;
		clear_all = 1'b0;
		st_we     = 1'b0;
		st_wdata  = TS_STOPPED;
		store_we  = 1'b0;
		emit      = 1'b0;
		emit_data = '0;
		unique case (state_q)
			BK_IDLE: begin
				op_ready = (op.op != OP_QUERY) || slot_free;
				if (op_valid && op_ready) begin
					unique case (op.op)
						OP_CONFIG: begin
							st_we    = op.idx_ok;
							st_wdata = TS_STOPPED;
						end
						OP_START: begin
							st_we    = op.idx_ok && (rd_status != TS_UNUSED);
							store_we = op.idx_ok && (rd_status != TS_UNUSED);
							st_wdata = TS_RUNNING;
						end
						OP_STOP: begin
							st_we    = op.idx_ok && (rd_status != TS_UNUSED);
							st_wdata = TS_STOPPED;
						end
						OP_RUN: run_start = 1'b1;
						OP_QUERY: begin
							emit                    = 1'b1;
							emit_data.result_kind   = KIND_QUERY;
							emit_data.expired_index = op.idx;
							emit_data.is_running    = op.idx_ok && (rd_status == TS_RUNNING);
							emit_data.last          = 1'b1;
						end
						OP_CLEAR: clear_all = 1'b1;
						default: ;
					endcase
				end
			end
			BK_SCAN: begin
				// an expiring entry waits for a free result slot
				scan_go = !expire || slot_free;
				if (scan_go && expire) begin
					st_we                   = 1'b1;
					st_wdata                = TS_COMPLETED;
					emit                    = 1'b1;
					emit_data.result_kind   = KIND_EXPIRY;
					emit_data.expired_index = 4'(cnt_q);
					emit_data.expired_param = param_q[cnt_q];
				end
			end
			BK_SUMMARY: begin
				if (slot_free) begin
					emit                    = 1'b1;
					emit_data.result_kind   = KIND_SUMMARY;
					emit_data.next_delay_ms = any_q ? best_q[30:0] : '0;
					emit_data.last          = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// timer status table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				status_q[i] <= TS_UNUSED;
			end
		end else if (clear_all) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				status_q[i] <= TS_UNUSED;
			end
		end else if (st_we) begin
			status_q[st_addr] <= st_wdata;
		end
	end

	// parameter and expiry stores
	always_ff @(posedge clk) begin
		if (store_we) begin
			param_q[op_addr]  <= op.param;
			expiry_q[op_addr] <= op.now + 32'(op.delay);
		end
	end

	// scan context
	always_ff @(posedge clk) begin
		if (run_start) begin
			now_q <= op.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
			best_q  <= '1;
			any_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (run_start) begin
				cnt_q  <= '0;
				best_q <= '1;
				any_q  <= 1'b0;
			end else if (scan_go) begin
				cnt_q <= cnt_q + 1'b1;
				if (scan_running && !expire && diff < best_q) begin
					best_q <= diff;
					any_q  <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_data;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a run command starts the scan at the first entry
	a_run_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_IDLE && take && op.op == OP_RUN) |=>
		(state_q == BK_SCAN && cnt_q == '0))
		else $error("run did not start scan at entry zero");

	// the last scanned entry leads to the summary
	a_scan_to_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN && scan_go && cnt_q == CNT_LAST) |=> (state_q == BK_SUMMARY))
		else $error("scan end did not reach summary");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |-> !emit)
		else $error("pending result overwritten");

	// a recorded least remaining time lies in the live half range
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> (best_q != '0 && best_q <= HALF_RANGE))
		else $error("least remaining time out of range");

endmodule

>>> src/multi_timer_expiry_table_unit.sv
// top level of the one-shot millisecond timer table
//
// Commands enter on the cmd channel (cmd_valid / cmd_ready, payload cmd) and
// results leave on the res channel (res_valid / res_ready, payload res).
// The front end takes a command whenever its two-entry queue has room,
// drops unknown command codes, and queues the rest for the back end.
// The back end owns the timer table and a single result register.
// Configure, start, stop and clear give no result. A query's answer passes
// through the queue and the result register before it is on res, and the
// back end takes a query only while the result slot is free. A run scan
// holds the back end while it takes the command, visits each table entry
// in turn and then gives the summary, giving one expiry event per running
// timer whose time has passed and then the summary marked last. The back
// end takes no new command until a scan's summary has been emitted.
// When the receiver stalls, the result register holds; the scan waits on
// any entry that must emit while new commands still fill the queue.
// Reset makes every timer unused and empties the queue and result register.
module multi_timer_expiry_table_unit
	import mte_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  mte_in_t  cmd,
	output logic     res_valid,
	input  logic     res_ready,
	output mte_out_t res
);

	logic    op_valid;
	logic    op_ready;
	mte_op_t op;

	// command intake and queue
	mte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op)
	);

	// table, scan and results
	mte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
